### src/form_query_splitter_decoder_macros.svh
// Assertion macros shared by the form query decoder RTL.
`ifndef FORM_QUERY_SPLITTER_DECODER_MACROS_SVH
`define FORM_QUERY_SPLITTER_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define FQSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge out of reset.
`define FQSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FQSD_ASSERT_NOW(label, ante, cons, msg)
`define FQSD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/fqsd_pkg.sv
// Types, character codes and hex helpers for the form query decoder.
package fqsd_pkg;

    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_SPC  = 8'h20;
    localparam logic [3:0] HEX_TEN = 4'hA;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       value_present;
        logic       query_done;
    } fqsd_res_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        begin
            v = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                v = c[3:0];
            end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
                v = HEX_TEN + (c[3:0] - 4'd1);
            end
            return v;
        end
    endfunction

endpackage

### src/form_query_splitter_decoder.sv
// The first result of an accepted transaction appears in the cycle after acceptance.
// One input transaction per cycle while each yields at most one result and m_ready is high;
// a transaction yielding k results (up to three, on a broken escape) holds the
// three-entry result buffer until all k have left; input is taken again as its last result leaves.
// Reset (aresetn low, synchronous) returns to the name part with no escape pending
// and an empty result buffer.
`include "form_query_splitter_decoder_macros.svh"

module form_query_splitter_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_end_of_query,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic       m_value_present,
    output logic       m_query_done,
    output logic       m_last
);
    import fqsd_pkg::*;

    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    logic       in_value_reg, in_value_next;
    logic [1:0] esc_reg, esc_next;
    logic [7:0] held_reg, held_next;

    fqsd_res_t  res_reg [MAX_RESULTS];
    fqsd_res_t  res_next [MAX_RESULTS];
    logic [1:0] cnt_next;
    logic [1:0] rem_reg;
    logic [1:0] idx_reg;

    logic       s_fire, m_fire;
    logic       c_hex, flush, do_plain;
    logic [1:0] byte_kind;
    fqsd_res_t  cur;

    assign m_valid = (rem_reg != 2'd0);
    assign m_fire  = m_valid && m_ready;
    // Input is taken when the buffer is empty or its final result leaves this cycle.
    assign s_ready = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_ready);
    assign s_fire  = s_valid && s_ready;

    assign cur             = res_reg[idx_reg];
    assign m_kind          = cur.kind;
    assign m_data_byte     = cur.data;
    assign m_value_present = cur.value_present;
    assign m_query_done    = cur.query_done;
    assign m_last          = (rem_reg == 2'd1);

    always_comb begin
        res_next[0]   = '0;
        res_next[1]   = '0;
        res_next[2]   = '0;
        cnt_next      = 2'd0;
        in_value_next = in_value_reg;
        esc_next      = esc_reg;
        held_next     = held_reg;
        do_plain      = 1'b0;
        c_hex         = is_hex(s_char_in);
        flush         = s_end_of_query || (esc_reg != ESC_NONE && !c_hex);
        byte_kind     = in_value_reg ? KIND_VALUE : KIND_NAME;

        // A broken or cut escape releases its held bytes literally, first.
        if (flush) begin
            if (esc_reg != ESC_NONE) begin
                res_next[cnt_next] = '{byte_kind, CH_PCT, 1'b0, 1'b0};
                cnt_next = cnt_next + 2'd1;
            end
            if (esc_reg == ESC_DIGIT) begin
                res_next[cnt_next] = '{byte_kind, held_reg, 1'b0, 1'b0};
                cnt_next = cnt_next + 2'd1;
            end
            esc_next  = ESC_NONE;
            held_next = 8'h00;
        end

        priority if (s_end_of_query) begin
            res_next[cnt_next] = '{KIND_END, 8'h00, in_value_reg, 1'b1};
            cnt_next      = cnt_next + 2'd1;
            in_value_next = 1'b0;
        end else if (esc_reg == ESC_PCT && c_hex) begin
            held_next = s_char_in;
            esc_next  = ESC_DIGIT;
        end else if (esc_reg == ESC_DIGIT && c_hex) begin
            res_next[cnt_next] = '{byte_kind, {hex_val(held_reg), hex_val(s_char_in)},
                                   1'b0, 1'b0};
            cnt_next  = cnt_next + 2'd1;
            esc_next  = ESC_NONE;
            held_next = 8'h00;
        end else begin
            do_plain = 1'b1;
        end

        if (do_plain) begin
            priority if (s_char_in == CH_EQ && !in_value_reg) begin
                in_value_next = 1'b1;
            end else if (s_char_in == CH_AMP) begin
                res_next[cnt_next] = '{KIND_END, 8'h00, in_value_reg, 1'b0};
                cnt_next      = cnt_next + 2'd1;
                in_value_next = 1'b0;
            end else if (s_char_in == CH_PCT) begin
                esc_next = ESC_PCT;
            end else if (s_char_in == CH_PLUS) begin
                res_next[cnt_next] = '{byte_kind, CH_SPC, 1'b0, 1'b0};
                cnt_next = cnt_next + 2'd1;
            end else begin
                res_next[cnt_next] = '{byte_kind, s_char_in, 1'b0, 1'b0};
                cnt_next = cnt_next + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_reg <= 1'b0;
            esc_reg      <= ESC_NONE;
            held_reg     <= 8'h00;
            rem_reg      <= 2'd0;
            idx_reg      <= 2'd0;
        end else begin
            if (s_fire) begin
                in_value_reg <= in_value_next;
                esc_reg      <= esc_next;
                held_reg     <= held_next;
                rem_reg      <= cnt_next;
                idx_reg      <= 2'd0;
            end else if (m_fire) begin
                rem_reg <= rem_reg - 2'd1;
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
            res_reg[2] <= res_next[2];
        end
    end

    `FQSD_ASSERT_NOW(a_end_is_last, m_valid && m_kind == KIND_END, m_last, "end marker not last")
    `FQSD_ASSERT_NOW(a_done_on_end, m_valid && m_query_done, m_kind == KIND_END, "stray done")
    `FQSD_ASSERT_NOW(a_end_zero_data, m_valid && m_kind == KIND_END, m_data_byte == 8'h00, "end data")
    `FQSD_ASSERT_NEXT(a_query_end_resets, s_fire && s_end_of_query, !in_value_reg && esc_reg == ESC_NONE, "state kept")
    `FQSD_ASSERT_NEXT(a_end_gives_result, s_fire && s_end_of_query, m_valid && m_query_done == (rem_reg == 2'd1 ? 1'b1 : m_query_done), "no end result")

endmodule
